// ===== sv/afu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the activation function unit.
// Used by afu_tanh, activation_function_unit_top and afu_checker.
package afu_pkg;

  // Function selected by the configuration register.
  typedef enum logic [1:0] {
    KIND_IDENTITY = 2'd0,
    KIND_RELU     = 2'd1,
    KIND_TANH     = 2'd2,
    KIND_SIGMOID  = 2'd3
  } kind_t;

  // Register stages from the input register to the output register inclusive.
  localparam int AFU_DEPTH = 8;

  // Register stages inside the tanh lookup and interpolation unit.
  localparam int TANH_STAGES = 4;

  // The tanh table covers magnitudes from 0 up to this bound.
  localparam int TANH_RANGE = 8;

  // One in Q32, the format of the exponential used to build the table.
  localparam logic [63:0] Q32 = 64'h1_0000_0000;

  // Restoring division for elaboration-time table construction only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] part;
    logic [63:0] quo;
    part = '0;
    quo  = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[63:0], num[i]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

// ===== sv/afu_tanh.sv =====
`timescale 1ns / 1ps
// Four-stage tanh of |z| by linear interpolation in a constant table.
// Depends on afu_pkg for the table-building constants and divider.
module afu_tanh import afu_pkg::*; #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic [TANH_STAGES-1:0] stg_en_i,
  input  logic [DATA_WIDTH-1:0]  raw_i,
  input  logic                   half_i,
  output logic [FRAC_BITS:0]     t_o
);

  localparam int OW  = FRAC_BITS + 1;
  localparam int TIW = $clog2(TABLE_ENTRIES + 1);
  localparam int NW  = DATA_WIDTH + TIW;
  localparam int SHT = FRAC_BITS + 3;
  localparam int SHS = FRAC_BITS + 4;
  localparam int RW  = SHS;
  localparam int NXW = NW + RW;
  localparam int PW  = OW + RW;

  localparam logic [NXW-1:0] MASK_T = (NXW'(1) << SHT) - NXW'(1);
  localparam logic [NXW-1:0] MASK_S = (NXW'(1) << SHS) - NXW'(1);
  localparam logic [PW:0]    RND_T  = (PW+1)'(1) << (SHT - 1);
  localparam logic [PW:0]    RND_S  = (PW+1)'(1) << (SHS - 1);
  localparam logic [OW-1:0]  ONE_O  = OW'(1) << FRAC_BITS;

  typedef logic [OW-1:0] tab_t [TABLE_ENTRIES+1];

  // Entry k is round(tanh(x) * 2^FRAC_BITS) at x = 8k/TABLE_ENTRIES, from
  // e^(-2x) held in Q32 and advanced by a fixed step factor.
  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] q;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] num;
    term = Q32;
    pos  = Q32;
    neg  = '0;
    p    = Q32;
    for (int n = 1; n < 30; n++) begin
      term = udiv64(term * 64'(2 * TANH_RANGE), 64'(TABLE_ENTRIES) * 64'(n));
      if ((n & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    q = pos - neg;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      den    = Q32 + p;
      num    = (Q32 - p) << FRAC_BITS;
      tab[k] = OW'(udiv64(num + (den >> 1), den));
      p      = (p * q + 64'h8000_0000) >> 32;
      if (p > Q32) begin
        p = Q32;
      end
    end
    return tab;
  endfunction

  localparam tab_t TAB = build_tab();

  // Stage 1: magnitude times table size.
  logic [DATA_WIDTH-1:0] mag;
  logic [NW-1:0]         num_nxt, num_r;
  logic                  half1_r;

  assign mag     = raw_i[DATA_WIDTH-1] ? (~raw_i + DATA_WIDTH'(1)) : raw_i;
  assign num_nxt = NW'(mag) * NW'(TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (stg_en_i[0]) begin
      num_r   <= num_nxt;
      half1_r <= half_i;
    end
  end

  // Stage 2: split into segment index and remainder, read both end points.
  logic [NXW-1:0] numx, idx;
  logic [TIW-1:0] idx_lo, idx_hi;
  logic           sat_nxt, sat2_r, half2_r;
  logic [RW-1:0]  rem_nxt, rem2_r;
  logic [OW-1:0]  lo_nxt, hi_nxt, lo2_r, hi2_r;

  always_comb begin
    numx    = NXW'(num_r);
    idx     = half1_r ? (numx >> SHS) : (numx >> SHT);
    rem_nxt = half1_r ? RW'(numx & MASK_S) : RW'(numx & MASK_T);
    sat_nxt = idx >= NXW'(TABLE_ENTRIES);
    idx_lo  = sat_nxt ? '0 : idx[TIW-1:0];
    idx_hi  = idx_lo + TIW'(1);
    lo_nxt  = TAB[idx_lo];
    hi_nxt  = TAB[idx_hi];
  end

  always_ff @(posedge clk) begin
    if (stg_en_i[1]) begin
      lo2_r   <= lo_nxt;
      hi2_r   <= hi_nxt;
      rem2_r  <= rem_nxt;
      sat2_r  <= sat_nxt;
      half2_r <= half1_r;
    end
  end

  // Stage 3: slope times remainder.
  logic [OW-1:0] diff;
  logic [PW-1:0] prod_nxt, prod3_r;
  logic [OW-1:0] lo3_r;
  logic          sat3_r, half3_r;

  assign diff     = (hi2_r > lo2_r) ? (hi2_r - lo2_r) : '0;
  assign prod_nxt = PW'(diff) * PW'(rem2_r);

  always_ff @(posedge clk) begin
    if (stg_en_i[2]) begin
      prod3_r <= prod_nxt;
      lo3_r   <= lo2_r;
      sat3_r  <= sat2_r;
      half3_r <= half2_r;
    end
  end

  // Stage 4: rounded step added to the lower point, or saturation to one.
  logic [PW:0]   step;
  logic [OW-1:0] t_nxt, t_r;

  always_comb begin
    step  = half3_r ? (((PW+1)'(prod3_r) + RND_S) >> SHS)
                    : (((PW+1)'(prod3_r) + RND_T) >> SHT);
    t_nxt = sat3_r ? ONE_O : (lo3_r + OW'(step));
  end

  always_ff @(posedge clk) begin
    if (stg_en_i[3]) begin
      t_r <= t_nxt;
    end
  end

  assign t_o = t_r;

endmodule

// ===== sv/activation_function_unit_top.sv =====
`timescale 1ns / 1ps
// Activation function unit: identity, ReLU, tanh or sigmoid, or the derivative, in Q4.12.
// Pipeline: eight register stages, from the input register to the output register.
// Throughput: one item per cycle; the pipeline moves whenever its output is taken or empty.
// Reset: synchronous, active low; clears all valid bits and sets the function to identity.
// Depends on afu_pkg and afu_tanh.
module activation_function_unit_top import afu_pkg::*; #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_sample_in,
  input  logic                         in_want_derivative,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_value_out
);

  localparam int OW = FRAC_BITS + 1;
  localparam int SW = 2 * OW;

  localparam logic [OW-1:0]         ONE_O    = OW'(1) << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] ONE_D    = DATA_WIDTH'(ONE_O);
  localparam logic [SW:0]           HALF_ONE = (SW+1)'(1) << (FRAC_BITS - 1);

  // Per-item side information carried alongside the tanh unit.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] raw;
    logic                  deriv;
    kind_t                 kind;
  } side_t;

  // The function register. The user must write it only while no item is in flight; the block does
  // not enforce it, and each item still carries its own copy down the pipeline.
  kind_t kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_IDENTITY;
    end else if (cfg_we) begin
      kind_r <= kind_t'(cfg_wdata);
    end
  end

  // Pipeline control. Stage i loads when it is empty or when the stage after
  // it moves on; the last stage is the output register, which moves when the
  // item is taken. Bubbles are squeezed out, so a stall never stops a stage
  // that has room.
  logic [AFU_DEPTH-1:0] v_r, v_nxt;
  logic [AFU_DEPTH:0]   en;

  always_comb begin
    en[AFU_DEPTH] = !out_stall;
    for (int i = AFU_DEPTH - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < AFU_DEPTH; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[AFU_DEPTH-1];

  // Stage 0 is the input register; stages 1 to TANH_STAGES run beside the
  // tanh unit and carry the raw sample, the derivative flag and the function.
  side_t side_r [TANH_STAGES+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= '{raw: in_sample_in, deriv: in_want_derivative, kind: kind_r};
    end
    for (int i = 1; i <= TANH_STAGES; i++) begin
      if (en[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Sigmoid reads tanh at half the argument, which is the same table walked
  // with one more fraction bit on the magnitude.
  logic [OW-1:0] t;

  afu_tanh #(
    .DATA_WIDTH   (DATA_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_tanh (
    .clk     (clk),
    .stg_en_i(en[TANH_STAGES:1]),
    .raw_i   (side_r[0].raw),
    .half_i  (side_r[0].kind == KIND_SIGMOID),
    .t_o     (t)
  );

  // Stage 5: activation value and the operands of the derivative product.
  // Identity and ReLU are finished here, derivatives included.
  side_t                 sd;
  logic                  neg;
  logic [OW:0]           s_sum;
  logic [OW-1:0]         s;
  logic [DATA_WIDTH-1:0] t_d;
  logic [DATA_WIDTH-1:0] act_nxt, act5_r;
  logic [OW-1:0]         ma_nxt, mb_nxt, ma5_r, mb5_r;
  logic                  need_nxt, need5_r, tanh_nxt, tanh5_r;

  always_comb begin
    sd     = side_r[TANH_STAGES];
    neg    = sd.raw[DATA_WIDTH-1];
    s_sum  = neg ? ((OW+1)'(ONE_O) - (OW+1)'(t) + (OW+1)'(1))
                 : ((OW+1)'(ONE_O) + (OW+1)'(t) + (OW+1)'(1));
    s      = OW'(s_sum >> 1);
    t_d    = DATA_WIDTH'(t);
    ma_nxt = t;
    mb_nxt = t;
    unique case (sd.kind)
      KIND_IDENTITY: begin
        act_nxt = sd.deriv ? ONE_D : sd.raw;
      end
      KIND_RELU: begin
        // The derivative at zero counts as one.
        act_nxt = neg ? '0 : (sd.deriv ? ONE_D : sd.raw);
      end
      KIND_TANH: begin
        act_nxt = neg ? (~t_d + DATA_WIDTH'(1)) : t_d;
      end
      KIND_SIGMOID: begin
        act_nxt = DATA_WIDTH'(s);
        ma_nxt  = s;
        mb_nxt  = ONE_O - s;
      end
      default: begin
        act_nxt = sd.raw;
      end
    endcase
    need_nxt = sd.deriv && ((sd.kind == KIND_TANH) || (sd.kind == KIND_SIGMOID));
    tanh_nxt = sd.kind == KIND_TANH;
  end

  always_ff @(posedge clk) begin
    if (en[TANH_STAGES+1]) begin
      act5_r  <= act_nxt;
      ma5_r   <= ma_nxt;
      mb5_r   <= mb_nxt;
      need5_r <= need_nxt;
      tanh5_r <= tanh_nxt;
    end
  end

  // Stage 6: the product t*t for tanh or s*(1-s) for sigmoid.
  logic [SW-1:0]         sq_nxt, sq6_r;
  logic [DATA_WIDTH-1:0] act6_r;
  logic                  need6_r, tanh6_r;

  assign sq_nxt = SW'(ma5_r) * SW'(mb5_r);

  always_ff @(posedge clk) begin
    if (en[TANH_STAGES+2]) begin
      sq6_r   <= sq_nxt;
      act6_r  <= act5_r;
      need6_r <= need5_r;
      tanh6_r <= tanh5_r;
    end
  end

  // Stage 7: round the product back to Q format and pick the result.
  logic [SW:0]           rnd;
  logic [SW:0]           drv;
  logic [DATA_WIDTH-1:0] out_value_nxt, out_value_r;

  always_comb begin
    rnd           = ((SW+1)'(sq6_r) + HALF_ONE) >> FRAC_BITS;
    drv           = tanh6_r ? ((SW+1)'(ONE_O) - rnd) : rnd;
    out_value_nxt = need6_r ? DATA_WIDTH'(drv) : act6_r;
  end

  always_ff @(posedge clk) begin
    if (en[AFU_DEPTH-1]) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_value_out = $signed(out_value_r);

endmodule

// ===== sv/afu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for activation_function_unit_top, bound to every instance.
// Depends on afu_pkg for the pipeline depth.
module afu_port_checker import afu_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] out_value_out
);

  localparam int CW = $clog2(AFU_DEPTH + 1);

  // Items accepted and not yet delivered.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_out))
    else $error("stalled result changed or vanished");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output side takes items");

  a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(AFU_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result shown with no item in flight");

endmodule

bind activation_function_unit_top afu_port_checker #(.DATA_WIDTH(DATA_WIDTH)) u_afu_checker (.*);

// ===== bench/afu_checker.sv =====
`timescale 1ns / 1ps
// Checker for the activation function unit: it watches both channels and the register port.
// It predicts each result and compares it with the block's output. Depends on afu_pkg.
module afu_checker import afu_pkg::*; #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_sample_in,
  input  logic                  in_want_derivative,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DATA_WIDTH-1:0] out_value_out,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] sample;
    logic                  deriv;
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] value;
  } activation_t;

  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

  longint unsigned tanh_points [TABLE_ENTRIES+1];
  activation_t     expected_activations [$];
  kind_t           active_kind;
  int              mismatches;
  int              seen_results;

  // Tanh at 8k/TABLE_ENTRIES, built from e^(-2x) in Q32 with rounded steps.
  initial begin : build_points
    longint unsigned term, pos, neg, q, p, den, num;
    term = Q32;
    pos  = Q32;
    neg  = 0;
    p    = Q32;
    for (int n = 1; n < 30; n++) begin
      term = (term * (2 * TANH_RANGE)) / (TABLE_ENTRIES * n);
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    q = pos - neg;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      den = Q32 + p;
      num = (Q32 - p) << FRAC_BITS;
      tanh_points[k] = (num + den / 2) / den;
      p = (p * q + (64'd1 << 31)) >> 32;
      if (p > Q32) p = Q32;
    end
    mismatches      = 0;
    seen_results    = 0;
    active_kind     = KIND_IDENTITY;
  end

  // Tanh of a magnitude read with fbits fraction bits, linearly interpolated.
  function automatic longint unsigned tanh_of_mag(longint unsigned mag, int fbits);
    longint unsigned span, scaled, idx, rem, lo, hi;
    span   = TANH_RANGE;
    span   = span << fbits;
    scaled = mag * TABLE_ENTRIES;
    idx    = scaled / span;
    rem    = scaled % span;
    if (idx >= TABLE_ENTRIES) return ONE;
    lo = tanh_points[idx];
    hi = tanh_points[idx + 1];
    if (hi <= lo) return lo;
    return lo + ((hi - lo) * rem + span / 2) / span;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] activation_of(logic [DATA_WIDTH-1:0] raw,
                                                          logic deriv, kind_t kind);
    logic            negative;
    longint unsigned mag, t, s, r;
    negative = raw[DATA_WIDTH-1];
    mag      = 64'(raw);
    // The most negative sample keeps its full magnitude.
    if (negative) mag = (64'd1 << DATA_WIDTH) - mag;
    case (kind)
      KIND_RELU: r = negative ? 64'd0 : (deriv ? ONE : mag);
      KIND_TANH: begin
        t = tanh_of_mag(mag, FRAC_BITS);
        if (deriv) r = ONE - ((t * t + ONE / 2) >> FRAC_BITS);
        else r = negative ? -t : t;
      end
      KIND_SIGMOID: begin
        // One more fraction bit halves the argument: s = (1 + tanh(z/2)) / 2.
        t = tanh_of_mag(mag, FRAC_BITS + 1);
        s = negative ? (ONE - t + 1) >> 1 : (ONE + t + 1) >> 1;
        r = deriv ? (s * (ONE - s) + ONE / 2) >> FRAC_BITS : s;
      end
      default: r = deriv ? ONE : (negative ? -mag : mag);
    endcase
    return r[DATA_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin : watch
    activation_t want;
    if (!rst_n) begin
      active_kind = KIND_IDENTITY;
      expected_activations.delete();
    end else begin
      // A result never comes from the item accepted at the same edge, so compare first.
      if (out_valid && !out_stall) begin
        seen_results++;
        if (expected_activations.size() == 0) begin
          mismatches++;
          $error("value_out with no item waiting: actual %0d", $signed(out_value_out));
        end else begin
          want = expected_activations.pop_front();
          if (out_value_out !== want.value) begin
            mismatches++;
            $error("value_out (%s, sample %0d, derivative %0b): expected %0d, actual %0d",
                   want.kind.name(), $signed(want.sample), want.deriv,
                   $signed(want.value), $signed(out_value_out));
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.sample = in_sample_in;
        want.deriv  = in_want_derivative;
        want.kind   = active_kind;
        want.value  = activation_of(in_sample_in, in_want_derivative, active_kind);
        expected_activations.push_back(want);
      end
      if (cfg_we) active_kind = kind_t'(cfg_wdata);
    end
    fail_count      <= mismatches;
    pending         <= expected_activations.size();
    results_checked <= seen_results;
  end

endmodule

// ===== bench/tb_activation_function_unit_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the activation function unit: stimulus, idle patterns and the verdict.
// Depends on afu_pkg, activation_function_unit_top and afu_checker.
module tb_activation_function_unit_top;
  import afu_pkg::*;

  localparam int DW             = 16;
  // Random items per phase; sixteen phases plus the edge-value items give about 1950.
  localparam int ITEMS_PER_SEG  = 120;
  // Cycles with no item moving on either channel before the run is declared hung.
  // The longest legal quiet stretch is the deliberate receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  logic          clk                = 1'b0;
  logic          rst_n              = 1'b0;
  logic          cfg_we             = 1'b0;
  logic [1:0]    cfg_wdata          = 2'd0;
  logic          in_valid           = 1'b0;
  logic          in_stall;
  logic [DW-1:0] in_sample_in       = '0;
  logic          in_want_derivative = 1'b0;
  logic          out_valid;
  logic          out_stall          = 1'b0;
  logic [DW-1:0] out_value_out;

  int fail_count;
  int pending;
  int results_checked;
  int items_sent     = 0;
  int quiet_cycles   = 0;
  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // One long receiver hold-off, requested by the stimulus and timed by the stall process.
  bit hold_request   = 1'b0;
  bit hold_taken     = 1'b0;
  int hold_left      = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  activation_function_unit_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_in       (in_sample_in),
    .in_want_derivative (in_want_derivative),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value_out      (out_value_out)
  );

  afu_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_in       (in_sample_in),
    .in_want_derivative (in_want_derivative),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value_out      (out_value_out),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_checked    (results_checked)
  );

  // Receiver side. While the hold-off runs, the output is stalled every cycle so the
  // pipeline fills and pushes back on the sender; otherwise it stalls at random.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= int'($urandom_range(99)) < recv_stall_pct;
    end
  end

  // Watchdog: a hang shows up as a long run of cycles in which no item moves.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles with %0d results pending.",
               quiet_cycles, pending);
      $display("[activation_function_unit_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, possibly after some idle cycles, and returns at the edge that takes it.
  // Valid stays high on return so back-to-back items need no extra assignment.
  task automatic send_item(input logic [DW-1:0] sample, input logic deriv);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sample_in       <= sample;
    in_want_derivative <= deriv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Lowers valid, then waits for a clock edge so the last accepted item is counted as pending,
  // and then until every expected result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The function register is only written with the pipeline empty.
  task automatic set_kind(input kind_t kind);
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random samples: a quarter each of full range, near zero, near the largest
  // magnitudes of either sign, and the special corner values.
  function automatic logic [DW-1:0] next_sample();
    logic [DW-1:0] v;
    case ($urandom_range(3))
      0: v = DW'($urandom);
      1: v = DW'($urandom_range(8191) - 4096);
      2: begin
        v = 16'h7FFF - DW'($urandom_range(511));
        if ($urandom_range(1) == 1) v = -v - 16'd1;
      end
      default: begin
        case ($urandom_range(4))
          0: v = 16'h0000;
          1: v = 16'h0001;
          2: v = 16'hFFFF;
          3: v = 16'h7FFF;
          default: v = 16'h8000;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    kind_t kind;
    int    mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sixteen phases: the function cycles through all four kinds, and every four phases
    // the idle pattern changes: none, sender idle, receiver stall, then both.
    // The first phase relies on the reset value of the register, identity.
    for (int seg = 0; seg < 16; seg++) begin
      kind = kind_t'(seg % 4);
      mode = seg / 4;
      if (seg != 0) set_kind(kind);
      send_idle_pct  = (mode == 1) ? 46 : (mode == 3) ? 17 : 0;
      recv_stall_pct <= (mode == 2) ? 46 : (mode == 3) ? 17 : 0;

      // Edge values for each function: zero with and without derivative (ReLU slope
      // at zero is one), the most negative sample, where tanh saturates and the
      // magnitude must not wrap, the largest positive sample, and minus one LSB.
      if (seg < 4) begin
        send_item(16'h0000, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h8000, 1'b1);
        send_item(16'h7FFF, 1'b1);
        send_item(16'hFFFF, 1'b0);
      end

      // The tanh phase without idling also carries the long receiver hold-off.
      if (seg == 2) hold_request <= 1'b1;

      repeat (ITEMS_PER_SEG) send_item(next_sample(), 1'($urandom_range(1)));
      drain();
    end

    // Give any stray result time to show up before the verdict.
    repeat (2 * AFU_DEPTH) @(posedge clk);

    $display("Covered %0d items over identity, ReLU, tanh and sigmoid, values and slopes,",
             items_sent);
    $display("under idle, stall and long back-pressure phases; %0d results compared.",
             results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[activation_function_unit_top] OK");
    end else begin
      $display("[activation_function_unit_top] ERROR");
    end
    $finish;
  end

endmodule
